// File: rtl/core/apc_pkg.sv
package apc_pkg;

  localparam int READING_W     = 16;
  localparam int COEF_W        = 32;
  localparam int NUM_COEF      = 6;
  localparam int TERM_CNT_W    = 3;
  localparam int CFG_ADDR_W    = 3;
  localparam int MAX_TERMS_DEF = 6;
  localparam int PROD_W        = COEF_W + READING_W + 1;
  localparam int TERM_W        = PROD_W - READING_W;
  localparam int ACC_W         = 36;
  localparam int VOLT_W        = 32;

  localparam logic [TERM_CNT_W-1:0] TERM_COUNT_RST = 3'd6;

  localparam logic [CFG_ADDR_W-1:0] REG_COEF_ZERO     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_ONE      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_TWO      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_THREE    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_FOUR     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_FIVE     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_OFFSET = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_TERM_COUNT    = 3'd7;

  typedef struct packed {
    logic [NUM_COEF-1:0][COEF_W-1:0] coef;
    logic [COEF_W-1:0]               offset;
    logic [TERM_CNT_W-1:0]           term_count;
  } apc_cfg_t;

  typedef struct packed {
    logic [READING_W-1:0]    u;
    logic [READING_W-1:0]    pw;
    logic signed [ACC_W-1:0]  sum;
    logic signed [TERM_W-1:0] term;
  } apc_stage_t;

endpackage

// File: rtl/core/apc_cfg_regs.sv
module apc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [apc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [apc_pkg::COEF_W-1:0]        cfg_data,
  output apc_pkg::apc_cfg_t                 cfg
);

  apc_pkg::apc_cfg_t cfg_r;
  apc_pkg::apc_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_addr)
        apc_pkg::REG_COEF_ZERO:     cfg_nxt.coef[0] = cfg_data;
        apc_pkg::REG_COEF_ONE:      cfg_nxt.coef[1] = cfg_data;
        apc_pkg::REG_COEF_TWO:      cfg_nxt.coef[2] = cfg_data;
        apc_pkg::REG_COEF_THREE:    cfg_nxt.coef[3] = cfg_data;
        apc_pkg::REG_COEF_FOUR:     cfg_nxt.coef[4] = cfg_data;
        apc_pkg::REG_COEF_FIVE:     cfg_nxt.coef[5] = cfg_data;
        apc_pkg::REG_OUTPUT_OFFSET: cfg_nxt.offset  = cfg_data;
        apc_pkg::REG_TERM_COUNT: begin
          cfg_nxt.term_count = cfg_data[apc_pkg::TERM_CNT_W-1:0];
        end
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef       <= '0;
      cfg_r.offset     <= '0;
      cfg_r.term_count <= apc_pkg::TERM_COUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: rtl/core/apc_term_stage.sv
module apc_term_stage #(
  parameter int K = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  apc_pkg::apc_cfg_t  cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  apc_pkg::apc_stage_t in_st,
  output logic               out_valid,
  input  logic               out_ready,
  output apc_pkg::apc_stage_t out_st
);

  localparam int CW = apc_pkg::TERM_CNT_W + 1;
  localparam logic [CW-1:0] K_V = CW'(K);
  localparam int RW = apc_pkg::READING_W;

  logic                               v_r;
  apc_pkg::apc_stage_t                st_r;
  logic                               en;
  logic                               active;
  logic signed [apc_pkg::COEF_W-1:0]  coef;
  logic signed [apc_pkg::PROD_W-1:0]  prod;
  logic [2*RW-1:0]                    pw_prod;

  generate
    if (K < apc_pkg::NUM_COEF) begin : g_coef
      assign coef = $signed(cfg.coef[K]);
    end else begin : g_nocoef
      assign coef = '0;
    end
  endgenerate

  assign en        = !v_r || out_ready;
  assign in_ready  = en;
  assign out_valid = v_r;
  assign out_st    = st_r;

  // Term K contributes only while the configured term count exceeds K.
  assign active  = {1'b0, cfg.term_count} > K_V;
  assign prod    = coef * $signed({1'b0, in_st.pw});
  assign pw_prod = in_st.pw * in_st.u;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      st_r.u    <= in_st.u;
      st_r.pw   <= pw_prod[2*RW-1:RW];
      st_r.sum  <= $signed(in_st.sum) + apc_pkg::ACC_W'($signed(in_st.term));
      st_r.term <= active ? $signed(prod[apc_pkg::PROD_W-1:RW]) : '0;
    end
  end

endmodule

// File: rtl/core/apc_sat_stage.sv
module apc_sat_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  apc_pkg::apc_stage_t           in_st,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [apc_pkg::VOLT_W-1:0]    voltage,
  output logic                          saturated
);

  localparam int AW = apc_pkg::ACC_W;
  localparam int VW = apc_pkg::VOLT_W;

  logic                 sum_v_r;
  logic signed [AW-1:0] sum_r;
  logic                 out_v_r;
  logic [VW-1:0]        voltage_r;
  logic                 saturated_r;
  logic                 en_sum;
  logic                 en_out;
  logic                 fits;

  assign en_out    = !out_v_r || out_ready;
  assign en_sum    = !sum_v_r || en_out;
  assign in_ready  = en_sum;
  assign out_valid = out_v_r;
  assign voltage   = voltage_r;
  assign saturated = saturated_r;

  // The sum fits when every bit above the 32-bit sign bit matches it.
  assign fits = (sum_r[AW-1:VW-1] == '0) || (sum_r[AW-1:VW-1] == '1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en_sum) begin
        sum_v_r <= in_valid;
      end
      if (en_out) begin
        out_v_r <= sum_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_sum && in_valid) begin
      sum_r <= $signed(in_st.sum) + AW'($signed(in_st.term));
    end
    if (en_out && sum_v_r) begin
      saturated_r <= !fits;
      if (fits) begin
        voltage_r <= sum_r[VW-1:0];
      end else if (sum_r[AW-1]) begin
        voltage_r <= {1'b1, {(VW-1){1'b0}}};
      end else begin
        voltage_r <= {1'b0, {(VW-1){1'b1}}};
      end
    end
  end

endmodule

// File: rtl/core/adc_polynomial_correction_unit.sv
// Channel  Direction  Handshake                 Payload
// in_      slave      in_tvalid / in_tready     tdata: reading[15:0]
// out_     master     out_tvalid / out_tready   tdata: voltage[31:0]; tuser: saturated
// cfg_     slave      cfg_valid / cfg_ready     cfg_addr: register index, cfg_data: value
//
// One reading is accepted per clock while no stall on the output holds it back. The
// pipeline has one stage per power term plus an entry stage, a final add stage and a
// saturation stage. Reset clears only the valid bits and the configuration registers.
// Each stage holds its item while the one after it is full and stalled, so empty
// stages keep accepting transactions during a stall on the output.
module adc_polynomial_correction_unit #(
  parameter int MAX_TERMS = apc_pkg::MAX_TERMS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // reading[15:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [31:0]                     out_tdata,  // voltage[31:0]
  output logic [0:0]                      out_tuser,  // saturated[0]
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [apc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [31:0]                     cfg_data
);

  localparam int AW = apc_pkg::ACC_W;

  apc_pkg::apc_cfg_t   cfg;
  apc_pkg::apc_stage_t st [MAX_TERMS];
  logic                v   [MAX_TERMS];
  logic                rdy [1:MAX_TERMS];
  apc_pkg::apc_stage_t st0_r;
  logic                v0_r;
  logic                en0;
  logic                saturated;

  apc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign en0       = !v0_r || rdy[1];
  assign in_tready = en0;
  assign st[0]     = st0_r;
  assign v[0]      = v0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en0) begin
      v0_r <= in_tvalid;
    end
  end

  // The constant term and the offset start the sum; the powers start at u.
  always_ff @(posedge clk) begin
    if (en0 && in_tvalid) begin
      st0_r.u    <= in_tdata;
      st0_r.pw   <= in_tdata;
      st0_r.sum  <= AW'($signed(cfg.coef[0])) + AW'($signed(cfg.offset));
      st0_r.term <= '0;
    end
  end

  generate
    for (genvar j = 1; j < MAX_TERMS; j++) begin : g_term
      apc_term_stage #(
        .K (j)
      ) u_term (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (v[j-1]),
        .in_ready  (rdy[j]),
        .in_st     (st[j-1]),
        .out_valid (v[j]),
        .out_ready (rdy[j+1]),
        .out_st    (st[j])
      );
    end
  endgenerate

  apc_sat_stage u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v[MAX_TERMS-1]),
    .in_ready  (rdy[MAX_TERMS]),
    .in_st     (st[MAX_TERMS-1]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .voltage   (out_tdata),
    .saturated (saturated)
  );

  assign out_tuser = saturated;

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata == 32'h7fff_ffff || out_tdata == 32'h8000_0000))
    else $error("saturated result does not hold a limit value");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while the output register is empty");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int MAX_TERMS      = apc_pkg::MAX_TERMS_DEF;
  localparam int PIPE_DEPTH     = MAX_TERMS + 2;
  localparam int LONG_HOLD      = 300;
  localparam int QUIET_LIMIT    = 4000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_READINGS = 240;
  localparam longint VOLT_MAX   = 64'sd2147483647;
  localparam longint VOLT_MIN   = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] voltage;
    logic        saturated;
  } volt_result_t;

  typedef enum logic {ROW_WRITE, ROW_READING} row_kind_e;

  typedef struct packed {
    row_kind_e    kind;
    logic [2:0]   addr;
    logic [31:0]  data;
    logic         typed;
    volt_result_t want;
  } stim_row_t;

  typedef enum logic [1:0] {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_MOSTLY} ready_pattern_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [apc_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [31:0] cfg_data = '0;

  logic signed [31:0] cal_coef [apc_pkg::NUM_COEF];
  logic signed [31:0] cal_offset;
  logic [2:0]         cal_terms;

  volt_result_t pending_voltages[$];
  stim_row_t    directed_rows[$];

  int errors = 0;
  int voltages_checked = 0;
  int clipped_seen = 0;
  int settings_applied = 0;
  int quiet_cycles = 0;
  int holds_requested = 0;
  int holds_started = 0;
  int hold_left = 0;
  int span_left = 0;
  ready_pattern_e ready_pattern = READY_ALWAYS;

  adc_polynomial_correction_unit #(.MAX_TERMS(MAX_TERMS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic volt_result_t correct_reading(input logic [15:0] reading);
    longint acc;
    longint power;
    int terms;
    volt_result_t res;
    acc = longint'(cal_coef[0]);
    power = longint'(reading);
    terms = (cal_terms > MAX_TERMS) ? MAX_TERMS : cal_terms;
    for (int k = 1; k < terms; k++) begin
      acc += (longint'(cal_coef[k]) * power) >>> 16;
      power = (power * longint'(reading)) >>> 16;
    end
    acc += longint'(cal_offset);
    res.saturated = 1'b0;
    if (acc > VOLT_MAX) begin
      acc = VOLT_MAX;
      res.saturated = 1'b1;
    end else if (acc < VOLT_MIN) begin
      acc = VOLT_MIN;
      res.saturated = 1'b1;
    end
    res.voltage = acc[31:0];
    return res;
  endfunction

  function automatic void add_write(input logic [2:0] addr, input logic [31:0] data);
    directed_rows.push_back('{ROW_WRITE, addr, data, 1'b0, '0});
  endfunction

  function automatic void add_reading(input logic [15:0] value);
    directed_rows.push_back('{ROW_READING, '0, {16'h0, value}, 1'b0, '0});
  endfunction

  function automatic void add_typed(input logic [15:0] value, input logic [31:0] volts,
                                    input logic sat);
    directed_rows.push_back('{ROW_READING, '0, {16'h0, value}, 1'b1, '{volts, sat}});
  endfunction

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      5: return 32'($urandom_range(0, 131071)) - 32'd65536;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_reading();
    case ($urandom_range(0, 11))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (addr)
      apc_pkg::REG_COEF_ZERO, apc_pkg::REG_COEF_ONE, apc_pkg::REG_COEF_TWO,
      apc_pkg::REG_COEF_THREE, apc_pkg::REG_COEF_FOUR,
      apc_pkg::REG_COEF_FIVE: cal_coef[addr] = data;
      apc_pkg::REG_OUTPUT_OFFSET: cal_offset = data;
      apc_pkg::REG_TERM_COUNT: cal_terms = data[2:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_reading(input logic [15:0] value, input logic typed,
                              input volt_result_t want);
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    pending_voltages.push_back(typed ? want : correct_reading(value));
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_voltages.size() != 0);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_started != holds_requested) begin
      out_tready <= 1'b0;
      holds_started <= holds_started + 1;
      hold_left <= LONG_HOLD;
    end else begin
      if (span_left == 0) begin
        ready_pattern <= ready_pattern_e'($urandom_range(0, 3));
        span_left <= $urandom_range(16, 160);
      end else begin
        span_left <= span_left - 1;
      end
      case (ready_pattern)
        READY_ALWAYS: out_tready <= 1'b1;
        READY_HALF:   out_tready <= $urandom_range(0, 1);
        READY_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        READY_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
        default:      out_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    volt_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_voltages.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, got voltage %h saturated %b",
                 $time, out_tdata, out_tuser[0]);
      end else begin
        want = pending_voltages.pop_front();
        voltages_checked++;
        if (out_tuser[0]) clipped_seen++;
        if (out_tdata !== want.voltage) begin
          errors++;
          $display("%0t: voltage expected %h, actual %h", $time, want.voltage, out_tdata);
        end
        if (out_tuser[0] !== want.saturated) begin
          errors++;
          $display("%0t: saturated expected %b, actual %b", $time, want.saturated,
                   out_tuser[0]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("adc_polynomial_correction_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int burst_left;
    int gap;
    for (int i = 0; i < apc_pkg::NUM_COEF; i++) cal_coef[i] = '0;
    cal_offset = '0;
    cal_terms  = apc_pkg::TERM_COUNT_RST;

    add_typed(16'h0000, 32'h0, 1'b0);
    add_typed(16'hFFFF, 32'h0, 1'b0);
    add_write(apc_pkg::REG_COEF_ZERO, 32'h7FFF_FFFF);
    add_write(apc_pkg::REG_OUTPUT_OFFSET, 32'h0000_0001);
    add_typed(16'h0000, 32'h7FFF_FFFF, 1'b1);
    add_write(apc_pkg::REG_COEF_ZERO, 32'h8000_0000);
    add_write(apc_pkg::REG_OUTPUT_OFFSET, 32'hFFFF_FFFF);
    add_typed(16'h1234, 32'h8000_0000, 1'b1);
    add_write(apc_pkg::REG_COEF_ZERO, 32'h0);
    add_write(apc_pkg::REG_OUTPUT_OFFSET, 32'h0);
    add_write(apc_pkg::REG_COEF_ONE, 32'h7FFF_FFFF);
    add_write(apc_pkg::REG_COEF_TWO, 32'h8000_0000);
    add_write(apc_pkg::REG_COEF_THREE, 32'h1234_5678);
    add_write(apc_pkg::REG_COEF_FOUR, 32'hFEDC_BA98);
    add_write(apc_pkg::REG_COEF_FIVE, 32'h4000_0000);
    add_write(apc_pkg::REG_TERM_COUNT, 32'hFFFF_FFF6);
    add_typed(16'h0000, 32'h0, 1'b0);
    add_reading(16'h0001);
    add_reading(16'h8000);
    add_reading(16'hFFFF);
    add_reading(16'h5555);
    add_reading(16'hAAAA);
    add_write(apc_pkg::REG_TERM_COUNT, 32'h0000_0008);
    add_reading(16'hFFFF);
    add_write(apc_pkg::REG_TERM_COUNT, 32'h0000_0007);
    add_reading(16'hFFFF);
    add_reading(16'h4321);
    add_write(apc_pkg::REG_TERM_COUNT, 32'h0000_0001);
    add_reading(16'hFFFF);
    add_write(apc_pkg::REG_TERM_COUNT, 32'h0000_0002);
    add_write(apc_pkg::REG_COEF_ONE, 32'hFFFF_FFFF);
    add_typed(16'h0001, 32'hFFFF_FFFF, 1'b0);
    add_reading(16'hFFFF);
    for (int r = 0; r < 7; r++) add_write(r[2:0], 32'h7FFF_FFFF);
    add_write(apc_pkg::REG_TERM_COUNT, 32'h0000_0006);
    add_reading(16'hFFFF);
    for (int r = 0; r < 7; r++) add_write(r[2:0], 32'h8000_0000);
    add_reading(16'hFFFF);
    add_reading(16'hC000);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        drain_results();
        write_reg(directed_rows[i].addr, directed_rows[i].data);
      end else begin
        send_reading(directed_rows[i].data[15:0], directed_rows[i].typed,
                     directed_rows[i].want);
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      for (int r = 0; r < 7; r++) write_reg(r[2:0], pick_coef());
      write_reg(apc_pkg::REG_TERM_COUNT,
                {29'($urandom_range(0, 32'h1FFF_FFFF)), phase[2:0]});
      settings_applied++;
      if (phase == 3) holds_requested <= holds_requested + 1;
      burst_left = 0;
      for (int n = 0; n < PHASE_READINGS; n++) begin
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          pause_sender(gap);
          burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        send_reading(pick_reading(), 1'b0, '0);
      end
    end

    drain_results();
    $display("Checked %0d corrected voltages, %0d of them clipped, over %0d random",
             voltages_checked, clipped_seen, settings_applied);
    $display("calibration settings plus directed extremes and term count edge cases.");
    if (errors == 0) begin
      $display("adc_polynomial_correction_unit: match");
    end else begin
      $display("adc_polynomial_correction_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: adc_polynomial_correction_unit.f
rtl/core/apc_pkg.sv
rtl/core/apc_cfg_regs.sv
rtl/core/apc_term_stage.sv
rtl/core/apc_sat_stage.sv
rtl/core/adc_polynomial_correction_unit.sv
verif/tb.sv
